// File: hw/rtl/ezr_pkg.sv
// Shared constants, types and arithmetic helpers for the Z-Y-X rotation matrix core.
package ezr_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int FRAC_BITS    = 14;
    localparam int OUT_WIDTH    = FRAC_BITS + 2;
    localparam int INT_FRAC     = 30;
    localparam int CORDIC_ITERS = 30;
    localparam int TURN_W       = 32;
    localparam int XY_W         = 34;
    localparam int Z_W          = 34;
    localparam int SC_W         = 32;
    localparam int SUM_W        = 34;
    localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
    localparam int EMIT_SHIFT   = INT_FRAC - FRAC_BITS;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
    localparam logic signed [SC_W-1:0] ONE_Q       = SC_W'(64'd1 << INT_FRAC);
    localparam logic signed [63:0]     QMUL_RND    = 64'sd1 <<< (INT_FRAC - 1);
    localparam logic signed [SUM_W-1:0] EMIT_RND   = SUM_W'((64'd1 << EMIT_SHIFT) >> 1);
    localparam logic signed [SUM_W-1:0] OUT_LIM    = SUM_W'(64'd1 << FRAC_BITS);

    typedef logic signed [SC_W-1:0] t_q30;

    // Arctangent of 2^-i in units of 2^-32 of a full turn.
    function automatic logic [TURN_W-1:0] atan_turn(input int i);
        logic [TURN_W-1:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10680094;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q30 times Q30 back to Q30, rounded half up.
    function automatic t_q30 qmul(input t_q30 a, input t_q30 b);
        logic signed [63:0] p;
        p = (64'(a) * 64'(b)) + QMUL_RND;
        return SC_W'(p >>> INT_FRAC);
    endfunction

    // Q30 sum to the output format, rounded half up and clipped to +-1.0.
    function automatic logic [OUT_WIDTH-1:0] emit(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        r = (v + EMIT_RND) >>> EMIT_SHIFT;
        if (r > OUT_LIM) begin
            r = OUT_LIM;
        end else if (r < -OUT_LIM) begin
            r = -OUT_LIM;
        end
        return r[OUT_WIDTH-1:0];
    endfunction

endpackage

// File: hw/rtl/ezr_cordic.sv
// Pipelined rotation-mode CORDIC giving the sine and cosine of one binary angle.
module ezr_cordic
    import ezr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [TURN_W-1:0] i_turn,
    output t_q30              o_sin,
    output t_q30              o_cos
);

    logic signed [XY_W-1:0] r_x [0:CORDIC_ITERS];
    logic signed [XY_W-1:0] r_y [0:CORDIC_ITERS];
    logic signed [Z_W-1:0]  r_z [0:CORDIC_ITERS];
    logic                   r_f [0:CORDIC_ITERS];
    t_q30                   r_sin, r_cos;

    logic              fold;
    logic [TURN_W-1:0] folded;

    // Angles in the second and third quadrant are turned by pi first.
    assign fold   = i_turn[TURN_W-1] ^ i_turn[TURN_W-2];
    assign folded = fold ? (i_turn ^ {1'b1, {(TURN_W-1){1'b0}}}) : i_turn;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= Z_W'(signed'(folded));
            r_f[0] <= fold;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - Z_W'(atan_turn(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + Z_W'(atan_turn(i));
                end
                r_f[i+1] <= r_f[i];
            end
        end
    end

    logic signed [XY_W-1:0] sx, sy;
    assign sx = r_f[CORDIC_ITERS] ? -r_x[CORDIC_ITERS] : r_x[CORDIC_ITERS];
    assign sy = r_f[CORDIC_ITERS] ? -r_y[CORDIC_ITERS] : r_y[CORDIC_ITERS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (sx > XY_W'(ONE_Q)) begin
                r_cos <= ONE_Q;
            end else if (sx < -XY_W'(ONE_Q)) begin
                r_cos <= -ONE_Q;
            end else begin
                r_cos <= SC_W'(sx);
            end
            if (sy > XY_W'(ONE_Q)) begin
                r_sin <= ONE_Q;
            end else if (sy < -XY_W'(ONE_Q)) begin
                r_sin <= -ONE_Q;
            end else begin
                r_sin <= SC_W'(sy);
            end
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// File: hw/rtl/euler_zyx_rotation_matrix_core.sv
// Top level of the Z-Y-X Euler angle to rotation matrix core.
//
// A request carries three binary angles (yaw, pitch, roll), each a signed
// word in which the full range spans -pi to pi. The block answers every
// request with the nine entries of Rz(yaw) * Ry(pitch) * Rx(roll) in signed
// Q2.14, each clipped to plus or minus 1.0.
// Both channels use valid and stall. A request is taken at a clock edge
// where i_valid is high and o_stall is low; a result leaves where o_valid
// is high and i_stall is low.
// The path is the CORDIC pipeline (fold, thirty iterations, clip), two product
// stages and the rounding and output stage. One request is taken in every
// cycle while o_stall is low.
// The whole pipeline advances as one; it only holds when a finished result
// sits in the output register and the receiver stalls, and then o_stall is
// raised so nothing is lost or repeated. Bubbles travel through freely.
// Reset clears the valid bits of every stage; the data registers are not
// reset.
module euler_zyx_rotation_matrix_core
    import ezr_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [ANGLE_WIDTH-1:0] i_yaw,
    input  logic signed [ANGLE_WIDTH-1:0] i_pitch,
    input  logic signed [ANGLE_WIDTH-1:0] i_roll,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [OUT_WIDTH-1:0]   o_r00,
    output logic signed [OUT_WIDTH-1:0]   o_r10,
    output logic signed [OUT_WIDTH-1:0]   o_r20,
    output logic signed [OUT_WIDTH-1:0]   o_r01,
    output logic signed [OUT_WIDTH-1:0]   o_r11,
    output logic signed [OUT_WIDTH-1:0]   o_r21,
    output logic signed [OUT_WIDTH-1:0]   o_r02,
    output logic signed [OUT_WIDTH-1:0]   o_r12,
    output logic signed [OUT_WIDTH-1:0]   o_r22
);

    logic en;
    logic r_out_valid;

    // The pipeline only freezes when the output register is full and stalled.
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // Binary angles are scaled to a 32-bit turn for the CORDIC.
    logic [TURN_W-1:0] turn_a, turn_b, turn_c;
    assign turn_a = TURN_W'(unsigned'(i_yaw))   << (TURN_W - ANGLE_WIDTH);
    assign turn_b = TURN_W'(unsigned'(i_pitch)) << (TURN_W - ANGLE_WIDTH);
    assign turn_c = TURN_W'(unsigned'(i_roll))  << (TURN_W - ANGLE_WIDTH);

    t_q30 sa, ca, sb, cb, sc, cc;

    ezr_cordic u_cordic_a (.i_clk(i_clk), .i_en(en), .i_turn(turn_a), .o_sin(sa), .o_cos(ca));
    ezr_cordic u_cordic_b (.i_clk(i_clk), .i_en(en), .i_turn(turn_b), .o_sin(sb), .o_cos(cb));
    ezr_cordic u_cordic_c (.i_clk(i_clk), .i_en(en), .i_turn(turn_c), .o_sin(sc), .o_cos(cc));

    // Valid bits that follow requests through the CORDIC pipeline.
    logic [CORDIC_LAT-1:0] r_vld;
    logic                  r_v1, r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[CORDIC_LAT-2:0], i_valid};
            r_v1        <= r_vld[CORDIC_LAT-1];
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    // First product stage: the pairwise products of the sines and cosines that the matrix needs.
    t_q30 r_scsb, r_ccsb, r_cacb, r_sacb, r_cbsc, r_cbcc;
    t_q30 r_sacc, r_cacc, r_sasc, r_casc, r_nsb, r1_sa, r1_ca;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_scsb <= qmul(sc, sb);
            r_ccsb <= qmul(cc, sb);
            r_cacb <= qmul(ca, cb);
            r_sacb <= qmul(sa, cb);
            r_cbsc <= qmul(cb, sc);
            r_cbcc <= qmul(cb, cc);
            r_sacc <= qmul(sa, cc);
            r_cacc <= qmul(ca, cc);
            r_sasc <= qmul(sa, sc);
            r_casc <= qmul(ca, sc);
            r_nsb  <= -sb;
            r1_sa  <= sa;
            r1_ca  <= ca;
        end
    end

    // Second product stage: yaw terms times the pitch-roll products.
    t_q30 r_ca_scsb, r_sa_scsb, r_ca_ccsb, r_sa_ccsb;
    t_q30 r2_cacb, r2_sacb, r2_cbsc, r2_cbcc, r2_sacc, r2_cacc, r2_sasc, r2_casc, r2_nsb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ca_scsb <= qmul(r1_ca, r_scsb);
            r_sa_scsb <= qmul(r1_sa, r_scsb);
            r_ca_ccsb <= qmul(r1_ca, r_ccsb);
            r_sa_ccsb <= qmul(r1_sa, r_ccsb);
            r2_cacb   <= r_cacb;
            r2_sacb   <= r_sacb;
            r2_cbsc   <= r_cbsc;
            r2_cbcc   <= r_cbcc;
            r2_sacc   <= r_sacc;
            r2_cacc   <= r_cacc;
            r2_sasc   <= r_sasc;
            r2_casc   <= r_casc;
            r2_nsb    <= r_nsb;
        end
    end

    // Sums, rounding to the output format and clipping, into the output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_r00 <= emit(SUM_W'(r2_cacb));
            o_r10 <= emit(SUM_W'(r2_sacb));
            o_r20 <= emit(SUM_W'(r2_nsb));
            o_r01 <= emit(SUM_W'(r_ca_scsb) - SUM_W'(r2_sacc));
            o_r11 <= emit(SUM_W'(r2_cacc) + SUM_W'(r_sa_scsb));
            o_r21 <= emit(SUM_W'(r2_cbsc));
            o_r02 <= emit(SUM_W'(r2_sasc) + SUM_W'(r_ca_ccsb));
            o_r12 <= emit(SUM_W'(r_sa_ccsb) - SUM_W'(r2_casc));
            o_r22 <= emit(SUM_W'(r2_cbcc));
        end
    end

    assign o_valid = r_out_valid;

endmodule
